// ----- hw/rtl/vpm_pkg.sv -----
// ----------------------------------------------------------------------------
// vpm_pkg: shared types and constants of the video page mapper
// Operation codes, controller states, and the command and status bundles
// that join the controller with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vpm_pkg;

  localparam int unsigned VideoPages = 64;
  localparam int unsigned PageBytes  = 256;
  localparam int unsigned PageW      = 6;
  localparam int unsigned KW         = 5;

  localparam logic [PageW-1:0] PalettePage  = 6'h3F;
  localparam logic [7:0]       PalAddrMask  = 8'h1F;
  localparam logic [7:0]       PalDataMask  = 8'h3F;
  localparam logic [7:0]       MirrorMask   = 8'hEF;
  localparam logic [7:0]       MirrorEntry  = 8'h10;
  localparam logic [7:0]       MirrorBase   = 8'h00;
  localparam logic [2:0]       MapSizeCount = 3'd5;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MAP   = 2'd2,
    OP_GHOST = 2'd3
  } vpm_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_RD_MEM,
    ST_WR_MEM,
    ST_WR_MIR,
    ST_MAP_RED,
    ST_MAP_WR,
    ST_MAP_GRD,
    ST_MAP_GWR,
    ST_GH_WR,
    ST_DONE
  } vpm_state_e;

  typedef struct packed {
    logic load;
    logic k_inc;
    logic k_grp;
    logic ph_sub;
    logic ph_inc;
    logic tab_rd;
    logic map_wr;
    logic ghost_copy;
    logic set_ghost;
    logic mem_rd;
    logic mem_wr;
    logic mirror_hi;
    logic out_load;
  } vpm_cmd_t;

  typedef struct packed {
    vpm_op_e op;
    logic    size_ok;
    logic    ghost_en;
    logic    page_valid;
    logic    mirror;
    logic    ph_ge;
    logic    grp_end;
    logic    last;
    logic    link_hit;
    logic    out_free;
  } vpm_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// vpm_ctrl: operation sequencer
// Steps each item through table lookup, backing memory access, the map
// walk with its ghost pass, the set-ghost write, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpm_pkg::vpm_sts_t  sts_i,
  output vpm_pkg::vpm_cmd_t  cmd_o
);

  vpm_pkg::vpm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == vpm_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      vpm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vpm_pkg::ST_DISP;
      end
      vpm_pkg::ST_DISP: begin
        case (sts_i.op)
          vpm_pkg::OP_READ:  state_d = sts_i.page_valid ? vpm_pkg::ST_RD_MEM
                                                        : vpm_pkg::ST_DONE;
          vpm_pkg::OP_WRITE: state_d = sts_i.page_valid ? vpm_pkg::ST_WR_MEM
                                                        : vpm_pkg::ST_DONE;
          vpm_pkg::OP_MAP:   state_d = sts_i.size_ok ? vpm_pkg::ST_MAP_RED
                                                     : vpm_pkg::ST_DONE;
          vpm_pkg::OP_GHOST: state_d = sts_i.ghost_en ? vpm_pkg::ST_GH_WR
                                                      : vpm_pkg::ST_DONE;
          default:           state_d = vpm_pkg::ST_DONE;
        endcase
      end
      vpm_pkg::ST_RD_MEM: state_d = vpm_pkg::ST_DONE;
      vpm_pkg::ST_WR_MEM: state_d = sts_i.mirror ? vpm_pkg::ST_WR_MIR : vpm_pkg::ST_DONE;
      vpm_pkg::ST_WR_MIR: state_d = vpm_pkg::ST_DONE;
      vpm_pkg::ST_MAP_RED: begin
        if (!sts_i.ph_ge) state_d = vpm_pkg::ST_MAP_WR;
      end
      vpm_pkg::ST_MAP_WR: begin
        if (sts_i.grp_end) state_d = vpm_pkg::ST_MAP_GRD;
      end
      vpm_pkg::ST_MAP_GRD, vpm_pkg::ST_MAP_GWR: begin
        if (state_q == vpm_pkg::ST_MAP_GRD && sts_i.link_hit) begin
          state_d = vpm_pkg::ST_MAP_GWR;
        end else if (sts_i.grp_end) begin
          state_d = sts_i.last ? vpm_pkg::ST_DONE : vpm_pkg::ST_MAP_WR;
        end else begin
          state_d = vpm_pkg::ST_MAP_GRD;
        end
      end
      vpm_pkg::ST_GH_WR: state_d = vpm_pkg::ST_DONE;
      vpm_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = vpm_pkg::ST_IDLE;
      end
      default: state_d = vpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      vpm_pkg::ST_IDLE: cmd_o.load = in_valid_i;
      vpm_pkg::ST_DISP: begin
        case (sts_i.op)
          vpm_pkg::OP_READ, vpm_pkg::OP_WRITE: cmd_o.tab_rd = sts_i.page_valid;
          vpm_pkg::OP_GHOST:                   cmd_o.tab_rd = sts_i.ghost_en;
          default:                             cmd_o.tab_rd = 1'b0;
        endcase
      end
      vpm_pkg::ST_RD_MEM: cmd_o.mem_rd = 1'b1;
      vpm_pkg::ST_WR_MEM: cmd_o.mem_wr = 1'b1;
      vpm_pkg::ST_WR_MIR: begin
        cmd_o.mem_wr    = 1'b1;
        cmd_o.mirror_hi = 1'b1;
      end
      vpm_pkg::ST_MAP_RED: cmd_o.ph_sub = sts_i.ph_ge;
      vpm_pkg::ST_MAP_WR: begin
        cmd_o.map_wr = 1'b1;
        cmd_o.ph_inc = 1'b1;
        cmd_o.k_grp  = sts_i.grp_end;
        cmd_o.k_inc  = !sts_i.grp_end;
      end
      vpm_pkg::ST_MAP_GRD, vpm_pkg::ST_MAP_GWR: begin
        if (state_q == vpm_pkg::ST_MAP_GRD && sts_i.link_hit) begin
          cmd_o.tab_rd = 1'b1;
        end else begin
          cmd_o.ghost_copy = (state_q == vpm_pkg::ST_MAP_GWR);
          cmd_o.k_inc      = !(sts_i.grp_end && sts_i.last);
        end
      end
      vpm_pkg::ST_GH_WR: cmd_o.set_ghost = 1'b1;
      vpm_pkg::ST_DONE:  cmd_o.out_load  = sts_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vpm_dp.sv -----
// ----------------------------------------------------------------------------
// vpm_dp: page mapper datapath
// Item registers, page map and ghost link tables, backing memory, map walk
// counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpm_dp #(
  parameter int unsigned PHYS_PAGES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        operation_i,
  input  logic [5:0]        page_i,
  input  logic [7:0]        offset_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        phys_page_i,
  input  logic [2:0]        map_size_i,
  input  logic [5:0]        ghost_page_i,
  input  logic              ghost_enable_i,
  input  vpm_pkg::vpm_cmd_t cmd_i,
  output vpm_pkg::vpm_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o,
  output logic              status_o
);

  localparam int unsigned PW       = $clog2(PHYS_PAGES);
  localparam int unsigned RW       = (PW > 8) ? PW : 8;
  localparam int unsigned MemAw    = PW + 8;
  localparam int unsigned MemDepth = PHYS_PAGES * vpm_pkg::PageBytes;
  localparam logic [RW:0] PhysLim  = (RW+1)'(PHYS_PAGES);

  localparam int unsigned PgW = vpm_pkg::PageW;
  localparam int unsigned KW  = vpm_pkg::KW;

  vpm_pkg::vpm_op_e op_q;
  logic [PgW-1:0]   page_q, first_q, gpage_q;
  logic [7:0]       off_q, wdata_q;
  logic [2:0]       msize_q;
  logic             gen_q;
  logic [RW-1:0]    ph_q, ph_d;
  logic [KW-1:0]    k_q, k_d;

  logic [KW-1:0]    cnt_m1;
  logic [2:0]       gmask;
  logic [PgW:0]     cur_p;
  logic             p_ok;

  logic [vpm_pkg::VideoPages-1:0] map_valid_q, link_valid_q;
  logic [PW-1:0]    phys_mem [vpm_pkg::VideoPages];
  logic [PgW-1:0]   link_mem [vpm_pkg::VideoPages];
  logic [PW-1:0]    tab_phys_q;
  logic [PgW-1:0]   tab_link_q;
  logic [PgW-1:0]   tab_raddr;

  logic             pm_we;
  logic [PgW-1:0]   pm_waddr;
  logic [PW-1:0]    pm_wdata;

  logic [7:0]       mem [MemDepth];
  logic [7:0]       mem_rdata_q;
  logic [7:0]       off_eff;
  logic [MemAw-1:0] mem_addr;
  logic             palette;

  logic             out_valid_q;
  logic [7:0]       out_data_q, out_data_d;
  logic             out_sts_q, out_sts_d;

  always_comb begin
    case (msize_q)
      3'd0:    begin cnt_m1 = KW'(0);  gmask = 3'd0; end
      3'd1:    begin cnt_m1 = KW'(3);  gmask = 3'd3; end
      3'd2:    begin cnt_m1 = KW'(7);  gmask = 3'd7; end
      3'd3:    begin cnt_m1 = KW'(15); gmask = 3'd7; end
      3'd4:    begin cnt_m1 = KW'(31); gmask = 3'd7; end
      default: begin cnt_m1 = KW'(0);  gmask = 3'd0; end
    endcase
  end

  assign cur_p   = {1'b0, first_q} + (PgW+1)'(k_q);
  assign p_ok    = !cur_p[PgW];
  assign palette = (page_q == vpm_pkg::PalettePage);

  always_comb begin
    k_d = k_q;
    if (cmd_i.k_grp) begin
      k_d = k_q & ~KW'(gmask);
    end else if (cmd_i.k_inc) begin
      k_d = k_q + KW'(1);
    end
    ph_d = ph_q;
    if (cmd_i.ph_sub) begin
      ph_d = RW'({1'b0, ph_q} - PhysLim);
    end else if (cmd_i.ph_inc) begin
      ph_d = (({1'b0, ph_q} + (RW+1)'(1)) == PhysLim) ? '0 : ph_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= vpm_pkg::vpm_op_e'(operation_i);
      page_q  <= page_i;
      first_q <= page_i;
      off_q   <= offset_i;
      wdata_q <= write_data_i;
      msize_q <= map_size_i;
      gpage_q <= ghost_page_i;
      gen_q   <= ghost_enable_i;
      ph_q    <= RW'(phys_page_i);
      k_q     <= '0;
    end else begin
      ph_q <= ph_d;
      k_q  <= k_d;
    end
  end

  always_comb begin
    case (op_q)
      vpm_pkg::OP_MAP:   tab_raddr = cur_p[PgW-1:0];
      vpm_pkg::OP_GHOST: tab_raddr = gpage_q;
      default:           tab_raddr = page_q;
    endcase
  end

  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = cur_p[PgW-1:0];
    pm_wdata = ph_q[PW-1:0];
    if (cmd_i.map_wr) begin
      pm_we = p_ok;
    end else if (cmd_i.ghost_copy) begin
      pm_we    = 1'b1;
      pm_waddr = tab_link_q;
      pm_wdata = tab_phys_q;
    end else if (cmd_i.set_ghost) begin
      pm_we    = 1'b1;
      pm_waddr = page_q;
      pm_wdata = tab_phys_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) phys_mem[pm_waddr] <= pm_wdata;
    if (cmd_i.set_ghost) link_mem[gpage_q] <= page_q;
    if (cmd_i.tab_rd) begin
      tab_phys_q <= phys_mem[tab_raddr];
      tab_link_q <= link_mem[tab_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q  <= '0;
      link_valid_q <= '0;
    end else begin
      if (cmd_i.map_wr && p_ok) begin
        map_valid_q[cur_p[PgW-1:0]] <= 1'b1;
      end else if (cmd_i.ghost_copy) begin
        map_valid_q[tab_link_q] <= map_valid_q[cur_p[PgW-1:0]];
      end else if (cmd_i.set_ghost) begin
        map_valid_q[page_q] <= map_valid_q[gpage_q];
      end
      if (cmd_i.set_ghost) link_valid_q[gpage_q] <= 1'b1;
    end
  end

  always_comb begin
    if (!palette) begin
      off_eff = off_q;
    end else if (sts_o.mirror) begin
      off_eff = cmd_i.mirror_hi ? vpm_pkg::MirrorEntry : vpm_pkg::MirrorBase;
    end else begin
      off_eff = off_q & vpm_pkg::PalAddrMask;
    end
  end

  assign mem_addr = {tab_phys_q, off_eff};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem[mem_addr] <= wdata_q;
    if (cmd_i.mem_rd) mem_rdata_q <= mem[mem_addr];
  end

  always_comb begin
    out_data_d = '0;
    if (op_q == vpm_pkg::OP_READ && map_valid_q[page_q]) begin
      out_data_d = palette ? (mem_rdata_q & vpm_pkg::PalDataMask) : mem_rdata_q;
    end
    out_sts_d = (op_q == vpm_pkg::OP_READ || op_q == vpm_pkg::OP_WRITE) &&
                !map_valid_q[page_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_data_d;
      out_sts_q  <= out_sts_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_sts_q;

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.size_ok    = (msize_q < vpm_pkg::MapSizeCount);
    sts_o.ghost_en   = gen_q;
    sts_o.page_valid = map_valid_q[page_q];
    sts_o.mirror     = palette && (op_q == vpm_pkg::OP_WRITE) &&
                       ((off_q & vpm_pkg::MirrorMask) == 8'h00);
    sts_o.ph_ge      = ({1'b0, ph_q} >= PhysLim);
    sts_o.grp_end    = ((k_q[2:0] & gmask) == gmask);
    sts_o.last       = (k_q == cnt_m1);
    sts_o.link_hit   = p_ok && link_valid_q[cur_p[PgW-1:0]];
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/video_page_mapper_palette_mirror.sv -----
// ----------------------------------------------------------------------------
// video_page_mapper_palette_mirror: paged video memory with palette mirror
// Maps 64 video pages of 256 bytes onto a backing memory through a page
// table with ghost links; reads, writes, map and set-ghost operations.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------
//   in      | input     | in_valid_i/in_ready_o   | operation, page, offset,
//           |           |                         | write_data, phys_page,
//           |           |                         | map_size, ghost_page,
//           |           |                         | ghost_enable
//   out     | output    | out_valid_o/out_ready_i | read_data, status
//
// One item at a time; each yields one result. Read, write and set-ghost
// make one table lookup and one access; a palette mirror write stores both
// mirror entries. Unmapped accesses, disabled set-ghost and unknown map sizes
// go straight to the result. Map subtracts PHYS_PAGES until phys_page is in
// range, writes its pages (walking past page 63 unwritten) and follows each
// group's ghost links. Tables and backing memory each have one read port.
// Reset clears all mappings and ghost links at once; no clearing pass.
// A waiting result does not block the next accept; a result is held in
// the done step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module video_page_mapper_palette_mirror #(
  parameter int unsigned PHYS_PAGES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [5:0] page_i,
  input  logic [7:0] offset_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] phys_page_i,
  input  logic [2:0] map_size_i,
  input  logic [5:0] ghost_page_i,
  input  logic       ghost_enable_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       status_o
);

  vpm_pkg::vpm_cmd_t cmd;
  vpm_pkg::vpm_sts_t sts;

  vpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vpm_dp #(
    .PHYS_PAGES (PHYS_PAGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .page_i         (page_i),
    .offset_i       (offset_i),
    .write_data_i   (write_data_i),
    .phys_page_i    (phys_page_i),
    .map_size_i     (map_size_i),
    .ghost_page_i   (ghost_page_i),
    .ghost_enable_i (ghost_enable_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .status_o       (status_o)
  );

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while previous result still waiting");

  a_write_mapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_wr |-> sts.page_valid)
    else $error("backing memory written through unmapped page");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while one is in work");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for video_page_mapper_palette_mirror
// Drives read, write, map and set-ghost items with random gaps on both
// channels. A tracker keeps its own page table, ghost links and backing
// bytes, predicts each result and compares it field by field on output.
// ----------------------------------------------------------------------------

localparam int unsigned PhysPages = 256;

typedef struct {
  vpm_pkg::vpm_op_e op;
  logic [5:0] page;
  logic [7:0] offset;
  logic [7:0] wdata;
  logic [7:0] phys;
  logic [2:0] msize;
  logic [5:0] gpage;
  logic       genable;
} vpm_item_t;

typedef struct packed {
  logic [7:0] rdata;
  logic       status;
} vpm_result_t;

class page_map_tracker;
  bit          map_ok[vpm_pkg::VideoPages];
  int unsigned map_phys[vpm_pkg::VideoPages];
  bit          link_ok[vpm_pkg::VideoPages];
  int unsigned link_to[vpm_pkg::VideoPages];
  bit [7:0]    mem_byte[PhysPages * vpm_pkg::PageBytes];
  bit          mem_written[PhysPages * vpm_pkg::PageBytes];
  vpm_result_t expected_q[$];
  int          errors;

  function int unsigned byte_addr(int unsigned pg, logic [7:0] off);
    return map_phys[pg] * vpm_pkg::PageBytes + off;
  endfunction

  function bit readable(logic [5:0] pg, logic [7:0] off);
    logic [7:0] eff;
    if (!map_ok[pg]) return 1'b1;
    eff = (pg == vpm_pkg::PalettePage) ? (off & vpm_pkg::PalAddrMask) : off;
    return mem_written[byte_addr(pg, eff)];
  endfunction

  function void store(logic [5:0] pg, logic [7:0] off, logic [7:0] data);
    int unsigned a;
    a = byte_addr(pg, off);
    mem_byte[a] = data;
    mem_written[a] = 1'b1;
  endfunction

  function void map_range(int unsigned first, int unsigned phys, logic [2:0] msize);
    int unsigned count, grp, p;
    if (msize >= vpm_pkg::MapSizeCount) return;
    count = (msize == 0) ? 1 : (2 << msize);
    grp = (count < 8) ? count : 8;
    for (int unsigned b = 0; b < count; b += grp) begin
      for (int unsigned i = 0; i < grp; i++) begin
        p = first + b + i;
        if (p < vpm_pkg::VideoPages) begin
          map_ok[p] = 1'b1;
          map_phys[p] = (phys + b + i) % PhysPages;
        end
      end
      for (int unsigned i = 0; i < grp; i++) begin
        p = first + b + i;
        if (p < vpm_pkg::VideoPages && link_ok[p]) begin
          map_ok[link_to[p]] = map_ok[p];
          map_phys[link_to[p]] = map_phys[p];
        end
      end
    end
  endfunction

  function void apply_item(vpm_item_t it);
    vpm_result_t r;
    r = '0;
    case (it.op)
      vpm_pkg::OP_READ: begin
        if (!map_ok[it.page]) begin
          r.status = 1'b1;
        end else if (it.page == vpm_pkg::PalettePage) begin
          r.rdata = mem_byte[byte_addr(it.page, it.offset & vpm_pkg::PalAddrMask)]
                    & vpm_pkg::PalDataMask;
        end else begin
          r.rdata = mem_byte[byte_addr(it.page, it.offset)];
        end
      end
      vpm_pkg::OP_WRITE: begin
        if (!map_ok[it.page]) begin
          r.status = 1'b1;
        end else if (it.page == vpm_pkg::PalettePage) begin
          if ((it.offset & vpm_pkg::MirrorMask) == vpm_pkg::MirrorBase) begin
            store(it.page, vpm_pkg::MirrorBase, it.wdata);
            store(it.page, vpm_pkg::MirrorEntry, it.wdata);
          end else begin
            store(it.page, it.offset & vpm_pkg::PalAddrMask, it.wdata);
          end
        end else begin
          store(it.page, it.offset, it.wdata);
        end
      end
      vpm_pkg::OP_MAP: map_range(it.page, it.phys, it.msize);
      vpm_pkg::OP_GHOST: begin
        if (it.genable) begin
          map_ok[it.page] = map_ok[it.gpage];
          map_phys[it.page] = map_phys[it.gpage];
          link_ok[it.gpage] = 1'b1;
          link_to[it.gpage] = it.page;
        end
      end
      default: begin
      end
    endcase
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [7:0] rdata, logic status);
    vpm_result_t e;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending: read_data %02h status %0b",
               $time, rdata, status);
      return;
    end
    e = expected_q.pop_front();
    if (rdata !== e.rdata) begin
      errors++;
      $display("%0t: read_data expected %02h actual %02h", $time, e.rdata, rdata);
    end
    if (status !== e.status) begin
      errors++;
      $display("%0t: status expected %0b actual %0b", $time, e.status, status);
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 200;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] operation_i;
  logic [5:0] page_i;
  logic [7:0] offset_i;
  logic [7:0] write_data_i;
  logic [7:0] phys_page_i;
  logic [2:0] map_size_i;
  logic [5:0] ghost_page_i;
  logic       ghost_enable_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] read_data_o;
  logic       status_o;

  page_map_tracker tracker = new();
  int unsigned     recent_writes[$];
  bit              in_steady;
  bit              out_steady;
  int unsigned     idle_cycles;

  video_page_mapper_palette_mirror #(
    .PHYS_PAGES    (PhysPages)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .page_i        (page_i),
    .offset_i      (offset_i),
    .write_data_i  (write_data_i),
    .phys_page_i   (phys_page_i),
    .map_size_i    (map_size_i),
    .ghost_page_i  (ghost_page_i),
    .ghost_enable_i(ghost_enable_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input vpm_item_t it);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i    = it.op;
    page_i         = it.page;
    offset_i       = it.offset;
    write_data_i   = it.wdata;
    phys_page_i    = it.phys;
    map_size_i     = it.msize;
    ghost_page_i   = it.gpage;
    ghost_enable_i = it.genable;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.apply_item(it);
    if (it.op == vpm_pkg::OP_WRITE) begin
      recent_writes.push_back(32'({it.page, it.offset}));
      if (recent_writes.size() > 64) void'(recent_writes.pop_front());
    end
    @(negedge clk_i);
  endtask

  task automatic send_fields(vpm_pkg::vpm_op_e op, logic [5:0] pg, logic [7:0] off,
                             logic [7:0] wd, logic [7:0] ph, logic [2:0] ms,
                             logic [5:0] gp, logic ge);
    vpm_item_t it;
    it = '{op, pg, off, wd, ph, ms, gp, ge};
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [5:0] random_page();
    return ($urandom_range(0, 7) == 0) ? vpm_pkg::PalettePage
                                       : 6'($urandom_range(0, 63));
  endfunction

  function automatic vpm_item_t next_random_item();
    vpm_item_t   it;
    int unsigned pick, key, sz;
    bit          found;
    it.op      = vpm_pkg::vpm_op_e'($urandom_range(0, 3));
    it.page    = 6'($urandom);
    it.offset  = 8'($urandom);
    it.wdata   = 8'($urandom);
    it.phys    = 8'($urandom);
    it.msize   = 3'($urandom);
    it.gpage   = 6'($urandom);
    it.genable = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.op = vpm_pkg::OP_READ;
      found = 1'b0;
      for (int t = 0; t < 8 && !found; t++) begin
        if (recent_writes.size() > 0 && $urandom_range(0, 3) != 0) begin
          key = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
          it.page   = key[13:8];
          it.offset = key[7:0];
        end else begin
          it.page   = random_page();
          it.offset = 8'($urandom);
        end
        found = tracker.readable(it.page, it.offset);
      end
      if (!found) it.op = vpm_pkg::OP_WRITE;
    end else if (pick < 75) begin
      it.op = vpm_pkg::OP_WRITE;
      found = 1'b0;
      for (int t = 0; t < 8 && !found; t++) begin
        it.page = random_page();
        found = tracker.map_ok[it.page];
      end
      if (it.page == vpm_pkg::PalettePage && $urandom_range(0, 2) == 0)
        it.offset = $urandom_range(0, 1) ? vpm_pkg::MirrorEntry : vpm_pkg::MirrorBase;
    end else if (pick < 90) begin
      it.op = vpm_pkg::OP_MAP;
      sz = $urandom_range(0, 99);
      if (sz < 30)      it.msize = 3'd0;
      else if (sz < 55) it.msize = 3'd1;
      else if (sz < 75) it.msize = 3'd2;
      else if (sz < 87) it.msize = 3'd3;
      else if (sz < 93) it.msize = 3'd4;
      else              it.msize = 3'($urandom_range(5, 7));
    end else begin
      it.op = vpm_pkg::OP_GHOST;
      it.genable = ($urandom_range(0, 4) != 0);
    end
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(read_data_o, status_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned gap;
    int unsigned served;
    out_ready_i = 1'b0;
    out_steady  = 1'b0;
    served      = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (served % 100 == 0) out_steady = ($urandom_range(0, 3) == 0);
      gap = out_steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      served++;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = vpm_pkg::OP_READ;
    page_i         = '0;
    offset_i       = '0;
    write_data_i   = '0;
    phys_page_i    = '0;
    map_size_i     = '0;
    ghost_page_i   = '0;
    ghost_enable_i = 1'b0;
    in_steady      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // unmapped accesses, unknown size, single page map
    send_fields(vpm_pkg::OP_READ,  6'd0, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, 6'd5, 8'h80, 8'h55, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_MAP,   6'd0, 8'h00, 8'h00, 8'h00, 3'd7, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_MAP,   6'd0, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, 6'd0, 8'h00, 8'hFF, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, 6'd0, 8'hFF, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ,  6'd0, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ,  6'd0, 8'hFF, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    // 32 pages up to the last page with backing wrap, then palette mirror and masks
    send_fields(vpm_pkg::OP_MAP, 6'd32, 8'h00, 8'h00, 8'hFA, 3'd4, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, vpm_pkg::PalettePage, 8'h10, 8'hAB, 8'h00, 3'd0,
                6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, vpm_pkg::PalettePage, 8'hE5, 8'h7F, 8'h00, 3'd0,
                6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, vpm_pkg::PalettePage, 8'hFF, 8'hC3, 8'h00, 3'd0,
                6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ, vpm_pkg::PalettePage, 8'hE0, 8'h00, 8'h00, 3'd0,
                6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ, vpm_pkg::PalettePage, 8'h10, 8'h00, 8'h00, 3'd0,
                6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ, vpm_pkg::PalettePage, 8'h25, 8'h00, 8'h00, 3'd0,
                6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ, vpm_pkg::PalettePage, 8'hFF, 8'h00, 8'h00, 3'd0,
                6'd0, 1'b0);
    // ghost disabled, ghost link, map through a ghost link
    send_fields(vpm_pkg::OP_GHOST, 6'd10, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ,  6'd10, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_GHOST, 6'd10, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b1);
    send_fields(vpm_pkg::OP_READ,  6'd10, 8'h00, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_MAP,   6'd0,  8'h00, 8'h00, 8'h64, 3'd1, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_WRITE, 6'd10, 8'h03, 8'h5A, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ,  6'd0,  8'h03, 8'h00, 8'h00, 3'd0, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_MAP,   6'd62, 8'h00, 8'h00, 8'hFF, 3'd2, 6'd0, 1'b0);
    send_fields(vpm_pkg::OP_READ, vpm_pkg::PalettePage, 8'h00, 8'h00, 8'h00, 3'd0,
                6'd0, 1'b0);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) in_steady = ($urandom_range(0, 3) == 0);
      if (n % 500 == 250) drain_results();
      send_item(next_random_item());
    end
    in_valid_i = 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/vpm_pkg.sv
hw/rtl/vpm_ctrl.sv
hw/rtl/vpm_dp.sv
hw/rtl/video_page_mapper_palette_mirror.sv
tb/tb.sv
